// File: src/cbf_pkg.sv
// Package for the circuit breaker core: mode codes, register indexes,
// reset values and the state, configuration and result structs.
// No dependencies.
package cbf_pkg;

  // Breaker modes
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_HALF   = 2'd2;

  // Operation codes of an input transaction
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_TICKS = 2'd2;

  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers
  localparam logic [15:0] FAILURE_LIMIT_RST  = 16'd5;
  localparam logic [15:0] SUCCESS_LIMIT_RST  = 16'd2;
  localparam logic [31:0] RECOVERY_TICKS_RST = 32'd30000;

  typedef struct packed {
    logic [15:0] failure_limit;
    logic [15:0] success_limit;
    logic [31:0] recovery_ticks;
  } cbf_cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] fail_run;
    logic [15:0] pass_run;
    logic [31:0] ticks;
    logic [31:0] requests;
    logic [31:0] passes;
    logic [31:0] fails;
    logic [31:0] rejects;
    logic [31:0] changes;
  } cbf_state_t;

  typedef struct packed {
    logic        admitted;
    logic [1:0]  mode;
    logic [15:0] failures;
    logic [31:0] requests;
    logic [31:0] passes;
    logic [31:0] fails;
    logic [31:0] rejects;
    logic [31:0] changes;
  } cbf_result_t;

endpackage

// File: src/cbf_step.sv
// Next-state logic of the circuit breaker for one transaction.
// Depends on cbf_pkg.
module cbf_step (
  input  cbf_pkg::cbf_state_t cur_i,
  input  cbf_pkg::cbf_cfg_t   cfg_i,
  input  logic                op_i,
  input  logic                failed_i,
  output cbf_pkg::cbf_state_t nxt_o,
  output logic                admitted_o
);
  import cbf_pkg::*;

  always_comb begin
    cbf_state_t s;
    logic       adm;
    s   = cur_i;
    adm = 1'b0;
    if (op_i == OP_TICK) begin
      if (s.ticks != '1) begin
        s.ticks = s.ticks + 32'd1;
      end
    end else begin
      s.requests = s.requests + 32'd1;
      adm        = 1'b1;
      if (s.mode == MODE_OPEN) begin
        if (s.ticks >= cfg_i.recovery_ticks) begin
          // trial request: go half-open and let it through
          s.mode     = MODE_HALF;
          s.changes  = s.changes + 32'd1;
          s.pass_run = '0;
        end else begin
          s.rejects = s.rejects + 32'd1;
          adm       = 1'b0;
        end
      end
      if (adm) begin
        if (failed_i) begin
          s.fails = s.fails + 32'd1;
          s.ticks = '0;
          case (s.mode)
            MODE_CLOSED: begin
              if (s.fail_run != '1) begin
                s.fail_run = s.fail_run + 16'd1;
              end
              if (s.fail_run >= cfg_i.failure_limit) begin
                s.mode    = MODE_OPEN;
                s.changes = s.changes + 32'd1;
              end
            end
            MODE_HALF: begin
              s.mode     = MODE_OPEN;
              s.changes  = s.changes + 32'd1;
              s.fail_run = cfg_i.failure_limit;
              s.pass_run = '0;
            end
            default: ;
          endcase
        end else begin
          s.passes = s.passes + 32'd1;
          case (s.mode)
            MODE_CLOSED: s.fail_run = '0;
            MODE_HALF: begin
              if (s.pass_run != '1) begin
                s.pass_run = s.pass_run + 16'd1;
              end
              if (s.pass_run >= cfg_i.success_limit) begin
                s.mode     = MODE_CLOSED;
                s.changes  = s.changes + 32'd1;
                s.fail_run = '0;
                s.pass_run = '0;
              end
            end
            default: ;
          endcase
        end
      end
    end
    nxt_o      = s;
    admitted_o = adm;
  end

endmodule

// File: src/circuit_breaker_fsm_core.sv
// Top level of the circuit breaker core: configuration registers, breaker
// state, result register and skid entry. Depends on cbf_pkg and cbf_step.
//
// Circuit breaker (closed / open / half-open). Each input transaction is a
// time tick (op 0) or a request carrying its downstream outcome (op 1), and
// produces exactly one result transaction giving the admit decision, the
// mode after the step, the current failure run and five wrapping totals.
// Throughput is one transaction per cycle while input is not stalled; the
// result of a taken input is registered. The whole state update is a
// single pass of compares and counter increments done at the accepting
// edge, so the next transaction sees the updated state straight away.
// Results sit in a result register backed by one skid entry: input is
// stalled only while both are full. Configuration (failure_limit index 0,
// success_limit 1, recovery_ticks 2, other indexes ignored) is written via
// cfg_we_i / cfg_idx_i / cfg_wdata_i, only while the core is idle: a rule
// for the user, not enforced. Reset: breaker closed, all counters at zero.
module circuit_breaker_fsm_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [cbf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cbf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic                              outcome_failed_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              admitted_o,
  output logic [1:0]                        breaker_mode_o,
  output logic [15:0]                       failures_seen_o,
  output logic [31:0]                       total_count_o,
  output logic [31:0]                       success_total_o,
  output logic [31:0]                       failure_total_o,
  output logic [31:0]                       reject_total_o,
  output logic [31:0]                       change_total_o
);
  import cbf_pkg::*;

  cbf_cfg_t    cfg_q;
  cbf_state_t  state_q, state_d;
  cbf_state_t  step_nxt;
  logic        step_adm;
  cbf_result_t step_res;

  cbf_result_t out_res_q, out_res_d;
  cbf_result_t skid_res_q, skid_res_d;
  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;

  logic in_acc, out_acc;

  // Stall input only when the skid entry is occupied
  assign in_acc  = in_valid_i & ~skid_valid_q;
  assign out_acc = out_valid_q & ~out_stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.failure_limit  <= FAILURE_LIMIT_RST;
      cfg_q.success_limit  <= SUCCESS_LIMIT_RST;
      cfg_q.recovery_ticks <= RECOVERY_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAILURE_LIMIT:  cfg_q.failure_limit  <= cfg_wdata_i[15:0];
        CFG_SUCCESS_LIMIT:  cfg_q.success_limit  <= cfg_wdata_i[15:0];
        CFG_RECOVERY_TICKS: cfg_q.recovery_ticks <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  cbf_step u_step (
    .cur_i      (state_q),
    .cfg_i      (cfg_q),
    .op_i       (op_i),
    .failed_i   (outcome_failed_i),
    .nxt_o      (step_nxt),
    .admitted_o (step_adm)
  );

  // Result as seen after the step
  always_comb begin
    step_res.admitted = step_adm;
    step_res.mode     = step_nxt.mode;
    step_res.failures = step_nxt.fail_run;
    step_res.requests = step_nxt.requests;
    step_res.passes   = step_nxt.passes;
    step_res.fails    = step_nxt.fails;
    step_res.rejects  = step_nxt.rejects;
    step_res.changes  = step_nxt.changes;
  end

  assign state_d = in_acc ? step_nxt : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{MODE_CLOSED, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                   32'd0, 32'd0};
    end else begin
      state_q <= state_d;
    end
  end

  // Result register with one skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    skid_valid_d = skid_valid_q;
    skid_res_d   = skid_res_q;
    if (out_acc || !out_valid_q) begin
      if (skid_valid_q) begin
        out_res_d    = skid_res_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_res_d   = step_res;
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_res_d   = step_res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign admitted_o      = out_res_q.admitted;
  assign breaker_mode_o  = out_res_q.mode;
  assign failures_seen_o = out_res_q.failures;
  assign total_count_o   = out_res_q.requests;
  assign success_total_o = out_res_q.passes;
  assign failure_total_o = out_res_q.fails;
  assign reject_total_o  = out_res_q.rejects;
  assign change_total_o  = out_res_q.changes;

endmodule
